@@ rtl/cspd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspd_pkg
// shared widths, fixed-point constants and types for the complex sample
// phase demodulator
// ----------------------------------------------------------------------------
package cspd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PHASE_BITS_DEF   = 32;

  localparam int RATE_W = 32;
  localparam int TIME_W = 32;

  // q30 fixed point
  localparam int          QB   = 30;
  localparam logic [30:0] QONE = 31'h4000_0000;

  // 2*pi in q29
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // latency of the sine/cosine series pipeline
  localparam int SC_LAT = 9;

  // exact reciprocal multipliers, m = ceil(2^sh / d) for 30-bit dividends
  localparam int COS_SH [4] = '{37, 36, 35, 34};
  localparam int SIN_SH [4] = '{37, 36, 35, 33};

  localparam logic [30:0] COS_M [4] = '{
    31'(((64'd1 << 37) + 64'd89) / 64'd90),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12)
  };

  localparam logic [30:0] SIN_M [4] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

endpackage

@@ rtl/cspd_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspd_sincos
// pipelined q30 cosine and sine of a small angle by horner taylor series,
// one multiply or one reciprocal multiply per stage
// ----------------------------------------------------------------------------
module cspd_sincos
  import cspd_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [QB-1:0] x_in,
  output logic [QB:0]   cos_out,
  output logic [QB-1:0] sin_out
);

  logic [QB-1:0] x2_d_r [8];
  logic [QB-1:0] xa_d_r [8];
  logic [QB:0]   c_r    [4];
  logic [QB:0]   s_r    [4];
  logic [QB-1:0] pc_r   [3];
  logic [QB-1:0] ps_r   [3];
  logic [QB:0]   cos_r;
  logic [QB-1:0] sin_r;

  // floor(a * b / 2^30), result known to stay below 2^30
  function automatic logic [QB-1:0] mulq(input logic [QB-1:0] a, input logic [QB:0] b);
    logic [60:0] prod;
    prod = 61'(a) * 61'(b);
    return prod[59:30];
  endfunction

  // floor(p / d) as (p * m) >> sh
  function automatic logic [QB-1:0] recip(input logic [QB-1:0] p, input logic [QB:0] m,
                                         input int sh);
    logic [60:0] prod;
    prod = 61'(p) * 61'(m);
    return QB'(prod >> sh);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      x2_d_r[0] <= mulq(x_in, {1'b0, x_in});
      xa_d_r[0] <= x_in;
      for (int i = 1; i < 8; i++) begin
        x2_d_r[i] <= x2_d_r[i-1];
        xa_d_r[i] <= xa_d_r[i-1];
      end
      c_r[0] <= QONE - {1'b0, recip(x2_d_r[0], COS_M[0], COS_SH[0])};
      s_r[0] <= QONE - {1'b0, recip(x2_d_r[0], SIN_M[0], SIN_SH[0])};
      for (int k = 1; k < 4; k++) begin
        pc_r[k-1] <= mulq(x2_d_r[2*k-1], c_r[k-1]);
        ps_r[k-1] <= mulq(x2_d_r[2*k-1], s_r[k-1]);
        c_r[k]    <= QONE - {1'b0, recip(pc_r[k-1], COS_M[k], COS_SH[k])};
        s_r[k]    <= QONE - {1'b0, recip(ps_r[k-1], SIN_M[k], SIN_SH[k])};
      end
      cos_r <= QONE - {1'b0, mulq(x2_d_r[7], c_r[3]) >> 1};
      sin_r <= mulq(xa_d_r[7], s_r[3]);
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

@@ rtl/complex_sample_phase_demodulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_sample_phase_demodulator
// rotates a complex sample by exp(i*2*pi*rate*time) with a pipelined
// phase multiply, taylor series sine/cosine and rounded, saturated mixer
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in_       slave      tvalid / tready    tdata: sample_real, sample_imag, sample_time
// out_      master     tvalid / tready    tdata: rotated_real, rotated_imag
// cfg_      write      wr_en              wr_data: demod_rate
//
// one transaction per clock in and out while out_tready does not hold the pipeline
// the pipeline depth is set by the nine-stage series evaluation plus phase,
// angle, quadrant, multiply and rounding stages
// reset clears the valid bits and the rate register
// when a result waits on out_tready the whole pipeline holds and in_tready drops
// ----------------------------------------------------------------------------
module complex_sample_phase_demodulator
  import cspd_pkg::*;
#(
  parameter int  SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int  PHASE_BITS   = PHASE_BITS_DEF,
  localparam int IN_W         = ((2 * SAMPLE_WIDTH + TIME_W + 7) / 8) * 8,
  localparam int OUT_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,     // sample_real, sample_imag, sample_time
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,    // rotated_real, rotated_imag
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data   // demod_rate
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int N_ST = SC_LAT + 5;
  localparam int PW   = SW + 32;

  localparam logic signed [PW:0] RND_HALF = (PW + 1)'(64'sd1 <<< (QB - 1));
  localparam logic signed [PW:0] SAT_HI   = (PW + 1)'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [PW:0] SAT_LO   = ~SAT_HI;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } samp_t;

  typedef struct packed {
    samp_t samp;
    quad_t quad;
    logic  neg;
  } side_t;

  logic                  stage_en;
  logic [N_ST-1:0]       vld_r;
  logic [RATE_W-1:0]     rate_r;

  logic [31:0]           ph_full;
  logic [PHASE_BITS-1:0] ph_r;
  samp_t                 samp1_r;

  logic [QB-1:0]         resid;
  logic [QB-1:0]         mag;
  logic [61:0]           ang_prod;
  side_t                 side2_nxt;
  side_t                 side2_r;
  logic [QB-1:0]         x_r;

  side_t                 side_d_r [SC_LAT];
  logic [QB:0]           cos_w;
  logic [QB-1:0]         sin_w;

  logic signed [31:0]    c0;
  logic signed [31:0]    s0;
  logic signed [31:0]    c_nxt;
  logic signed [31:0]    s_nxt;
  logic signed [31:0]    c_r;
  logic signed [31:0]    s_r;
  samp_t                 samp12_r;

  logic signed [PW-1:0]  rc_r;
  logic signed [PW-1:0]  is_r;
  logic signed [PW-1:0]  rs_r;
  logic signed [PW-1:0]  ic_r;

  logic signed [SW-1:0]  out_real_r;
  logic signed [SW-1:0]  out_imag_r;

  function automatic logic signed [SW-1:0] rnd_sat(input logic signed [PW:0] v);
    logic signed [PW:0] rv;
    rv = (v + RND_HALF) >>> QB;
    if (rv > SAT_HI) begin
      return SAT_HI[SW-1:0];
    end else if (rv < SAT_LO) begin
      return SAT_LO[SW-1:0];
    end else begin
      return rv[SW-1:0];
    end
  endfunction

  assign stage_en  = !vld_r[N_ST-1] || out_tready;
  assign in_tready = stage_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else if (cfg_wr_en) begin
      rate_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (stage_en) begin
      vld_r <= {vld_r[N_ST-2:0], in_tvalid};
    end
  end

  // phase, wrapped to one cycle and truncated
  assign ph_full = rate_r * in_tdata[2*SW+TIME_W-1:2*SW];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      ph_r    <= ph_full[31:32-PHASE_BITS];
      samp1_r <= '{re: in_tdata[SW-1:0], im: in_tdata[2*SW-1:SW]};
    end
  end

  // quadrant and signed residual angle
  always_comb begin
    resid          = QB'(ph_r[PHASE_BITS-3:0]) << (32 - PHASE_BITS);
    side2_nxt.samp = samp1_r;
    side2_nxt.neg  = resid[QB-1];
    side2_nxt.quad = quad_t'(ph_r[PHASE_BITS-1:PHASE_BITS-2] + {1'b0, resid[QB-1]});
    mag            = resid[QB-1] ? QB'(-resid) : resid;
    ang_prod       = 62'(mag) * 62'(TWO_PI_Q29);
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      side2_r <= side2_nxt;
      x_r     <= ang_prod[60:31];
    end
  end

  cspd_sincos u_sincos (
    .clk     (clk),
    .en      (stage_en),
    .x_in    (x_r),
    .cos_out (cos_w),
    .sin_out (sin_w)
  );

  always_ff @(posedge clk) begin
    if (stage_en) begin
      side_d_r[0] <= side2_r;
      for (int i = 1; i < SC_LAT; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  // quadrant mapping
  always_comb begin
    c0 = $signed({1'b0, cos_w});
    s0 = side_d_r[SC_LAT-1].neg ? -$signed({2'b00, sin_w}) : $signed({2'b00, sin_w});
    case (side_d_r[SC_LAT-1].quad)
      QUAD_0: begin
        c_nxt = c0;
        s_nxt = s0;
      end
      QUAD_1: begin
        c_nxt = -s0;
        s_nxt = c0;
      end
      QUAD_2: begin
        c_nxt = -c0;
        s_nxt = -s0;
      end
      QUAD_3: begin
        c_nxt = s0;
        s_nxt = -c0;
      end
      default: begin
        c_nxt = c0;
        s_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      c_r      <= c_nxt;
      s_r      <= s_nxt;
      samp12_r <= side_d_r[SC_LAT-1].samp;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      rc_r <= $signed(PW'(samp12_r.re)) * $signed(PW'(c_r));
      is_r <= $signed(PW'(samp12_r.im)) * $signed(PW'(s_r));
      rs_r <= $signed(PW'(samp12_r.re)) * $signed(PW'(s_r));
      ic_r <= $signed(PW'(samp12_r.im)) * $signed(PW'(c_r));
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      out_real_r <= rnd_sat($signed((PW + 1)'(rc_r)) - $signed((PW + 1)'(is_r)));
      out_imag_r <= rnd_sat($signed((PW + 1)'(rs_r)) + $signed((PW + 1)'(ic_r)));
    end
  end

  assign out_tvalid = vld_r[N_ST-1];
  assign out_tdata  = OUT_W'({out_imag_r, out_real_r});

endmodule

@@ test/cspd_rotation_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspd_rotation_monitor
// watches the sample, result and rate-register ports of the complex sample
// phase demodulator, predicts each rotated sample in q30 fixed point and
// compares every result transaction with the oldest prediction in order
// ----------------------------------------------------------------------------
module cspd_rotation_monitor
  import cspd_pkg::*;
#(
  parameter int  SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int  PHASE_BITS   = PHASE_BITS_DEF,
  localparam int IN_W         = ((2 * SAMPLE_WIDTH + TIME_W + 7) / 8) * 8,
  localparam int OUT_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,     // sample_real, sample_imag, sample_time
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,    // rotated_real, rotated_imag
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data,  // demod_rate
  output int                mismatch_count,
  output int                pending_results
);

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_29 = 64'd3373259426;
  localparam longint      RESID_MID = longint'(1) << 29;
  localparam longint      QUAD_SPAN = longint'(1) << 30;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
  } rotated_t;

  rotated_t    rotated_q[$];
  logic [31:0] rate_shadow;

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_saturate(input longint v);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    r  = (v + RESID_MID) >>> 30;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic rotated_t rotate_by_phase(input logic [31:0] rate,
                                               input logic signed [SAMPLE_WIDTH-1:0] re,
                                               input logic signed [SAMPLE_WIDTH-1:0] im,
                                               input logic [31:0] t);
    logic [31:0] ph;
    logic [1:0]  qbits;
    quad_t       quad;
    longint      resid;
    bit          neg;
    logic [63:0] mag;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ct;
    logic [63:0] st;
    longint      c0;
    longint      s0;
    longint      c;
    longint      s;
    rotated_t    res;
    ph    = rate * t;
    ph    = ph & (32'hFFFF_FFFF << (32 - PHASE_BITS));
    qbits = ph[31:30];
    resid = ph[29:0];
    // upper half of a quadrant folds into the next one as a negative residual
    if (resid >= RESID_MID) begin
      resid = resid - QUAD_SPAN;
      qbits = qbits + 2'd1;
    end
    quad = quad_t'(qbits);
    neg  = resid < 0;
    mag  = neg ? 64'(-resid) : 64'(resid);
    x    = (mag * TWO_PI_29) >> 31;
    x2   = mul_q30(x, x);

    ct = Q30_ONE - x2 / 64'd90;
    ct = Q30_ONE - mul_q30(x2, ct) / 64'd56;
    ct = Q30_ONE - mul_q30(x2, ct) / 64'd30;
    ct = Q30_ONE - mul_q30(x2, ct) / 64'd12;
    ct = Q30_ONE - mul_q30(x2, ct) / 64'd2;

    st = Q30_ONE - x2 / 64'd72;
    st = Q30_ONE - mul_q30(x2, st) / 64'd42;
    st = Q30_ONE - mul_q30(x2, st) / 64'd20;
    st = Q30_ONE - mul_q30(x2, st) / 64'd6;
    st = mul_q30(x, st);

    c0 = longint'(ct);
    s0 = neg ? -longint'(st) : longint'(st);
    case (quad)
      QUAD_0: begin c = c0;  s = s0;  end
      QUAD_1: begin c = -s0; s = c0;  end
      QUAD_2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase

    res.re = round_saturate(longint'(re) * c - longint'(im) * s);
    res.im = round_saturate(longint'(re) * s + longint'(im) * c);
    return res;
  endfunction

  always @(posedge clk) begin
    rotated_t                       exp_res;
    logic signed [SAMPLE_WIDTH-1:0] act_re;
    logic signed [SAMPLE_WIDTH-1:0] act_im;
    if (!rst_n) begin
      rate_shadow = '0;
      rotated_q.delete();
      mismatch_count  <= 0;
      pending_results <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rotated_q.push_back(rotate_by_phase(rate_shadow,
                                            in_tdata[SAMPLE_WIDTH-1:0],
                                            in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH],
                                            in_tdata[2*SAMPLE_WIDTH+TIME_W-1:2*SAMPLE_WIDTH]));
      end
      if (out_tvalid && out_tready) begin
        act_re = out_tdata[SAMPLE_WIDTH-1:0];
        act_im = out_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        if (rotated_q.size() == 0) begin
          $error("unexpected result transaction: rotated_real %0d, rotated_imag %0d",
                 act_re, act_im);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_res = rotated_q.pop_front();
          if (act_re !== exp_res.re || act_im !== exp_res.im) begin
            mismatch_count <= mismatch_count + 1;
          end
          if (act_re !== exp_res.re) begin
            $error("rotated_real mismatch: expected %0d, actual %0d", exp_res.re, act_re);
          end
          if (act_im !== exp_res.im) begin
            $error("rotated_imag mismatch: expected %0d, actual %0d", exp_res.im, act_im);
          end
        end
      end
      if (cfg_wr_en) begin
        rate_shadow = cfg_wr_data;
      end
      pending_results <= rotated_q.size();
    end
  end

endmodule

@@ test/tb_complex_sample_phase_demodulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_sample_phase_demodulator
// drives samples and rate settings into the phase demodulator: a directed
// pass over quadrant edges, full-scale and negative rates, then random
// samples over several rate settings, mostly with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_complex_sample_phase_demodulator;
  import cspd_pkg::*;

  localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF;
  localparam int PHASE_BITS   = PHASE_BITS_DEF;
  localparam int IN_W         = ((2 * SAMPLE_WIDTH + TIME_W + 7) / 8) * 8;
  localparam int OUT_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en = 1'b0;
  logic [RATE_W-1:0] cfg_wr_data = '0;
  bit                quiet = 1'b0;
  int                mismatch_count;
  int                pending_results;
  int                stall_cycles = 0;

  complex_sample_phase_demodulator #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .PHASE_BITS  (PHASE_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cspd_rotation_monitor #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .PHASE_BITS  (PHASE_BITS)
  ) i_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] re,
                             input logic [SAMPLE_WIDTH-1:0] im,
                             input logic [TIME_W-1:0] t);
    if (!quiet) begin
      while ($urandom_range(99) < 7) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, im, re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(7))
      0: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      2: return '0;
      3: return SAMPLE_WIDTH'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return TIME_W'($urandom_range(0, 1023));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [RATE_W-1:0] rate;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rate left at its reset value: identity rotation
    send_sample(16'h7FFF, 16'h7FFF, 32'd777);
    send_sample(16'h8000, 16'h8000, 32'd0);
    send_sample(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    send_sample(16'h0000, 16'h0000, 32'd12345);

    // quarter turn per tick
    write_rate(32'h4000_0000);
    send_sample(16'd1000, -16'sd2000, 32'd1);
    send_sample(16'h8000, 16'h0000, 32'd3);
    send_sample(16'h7FFF, 16'h8000, 32'd2);

    // eighth turn sits on the residual fold, full scale saturates at 45 degrees
    write_rate(32'h2000_0000);
    send_sample(16'h8000, 16'h8000, 32'd1);
    send_sample(16'h7FFF, 16'h7FFF, 32'd1);
    send_sample(16'h7FFF, 16'h8000, 32'hFFFF_FFFF);

    // most negative rate
    write_rate(32'h8000_0000);
    send_sample(16'h8000, 16'h8000, 32'd1);
    send_sample(16'd12345, -16'sd321, 32'hFFFF_FFFF);

    // most positive rate
    write_rate(32'h7FFF_FFFF);
    send_sample(16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
    send_sample(-16'sd30000, 16'd29999, 32'h8000_0000);

    // negative quarter turn and smallest negative step
    write_rate(32'hC000_0000);
    send_sample(16'd20000, 16'd10000, 32'd1);
    send_sample(16'h8000, 16'h7FFF, 32'd5);
    write_rate(32'hFFFF_FFFF);
    send_sample(16'h7FFF, 16'h0001, 32'd1);

    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      case (ph_i)
        1: rate = 32'h7FFF_FFFF;
        3: rate = 32'h8000_0000;
        5: rate = ($urandom_range(1) != 0) ? 32'($urandom_range(0, 4095))
                                           : -32'($urandom_range(0, 4095));
        7: rate = 32'h0000_0000;
        default: rate = $urandom;
      endcase
      write_rate(rate);
      quiet <= (ph_i == 5);
      for (int k = 0; k < 105; k++) begin
        // hold the sender until the pipeline has emptied
        if (ph_i == 2 && k == 50) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        send_sample(pick_sample(), pick_sample(), pick_time());
      end
    end

    quiet     <= 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
